### hdl/dur_pkg.sv
// Shared types and constants for the dual ultrasonic range and direction unit
`timescale 1ns / 1ps
`default_nettype none

package dur_pkg;

  // default parameter values
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int STAMP_WIDTH_DEF = 32;

  // fixed field widths
  localparam int TRIG_W     = 10;
  localparam int WIN_W      = 16;
  localparam int DIST_W     = 14;
  localparam int REM_W      = 7;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_TRIG_LEN = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_WIN_MIN  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_WIN_MAX  = 2'd2;

  // register reset values
  localparam logic [TRIG_W-1:0] TRIG_LEN_RST = 10'd10;
  localparam logic [WIN_W-1:0]  WIN_MIN_RST  = 16'd1177;
  localparam logic [WIN_W-1:0]  WIN_MAX_RST  = 16'd5882;

  // distance scale: mm = count * 17 / 100
  localparam logic [REM_W-1:0]  DIST_NUM = 7'd17;
  localparam logic [REM_W-1:0]  DIST_DEN = 7'd100;
  localparam logic [DIST_W-1:0] DIST_MAX = 14'h3FFF;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TRIG,
    PH_WAIT,
    PH_COUNT
  } phase_t;

  typedef struct packed {
    logic [TRIG_W-1:0] trig_len;
    logic [WIN_W-1:0]  win_min;
    logic [WIN_W-1:0]  win_max;
  } cfg_t;

  typedef struct packed {
    logic trig;
    logic done;
    logic hit;
  } chan_stat_t;

endpackage

`default_nettype wire

### hdl/dur_channel.sv
// One ranging channel: trigger pulse, echo timing and running distance
`timescale 1ns / 1ps
`default_nettype none

module dur_channel
  import dur_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic              arm,
  input  wire logic              echo,
  input  wire cfg_t              cfg,
  output chan_stat_t             stat,
  output logic [DIST_W-1:0]      range_mm
);

  localparam int CMP_W = (COUNT_WIDTH > WIN_W) ? COUNT_WIDTH : WIN_W;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  phase_t                 phase_r, phase_nxt;
  logic [TRIG_W-1:0]      left_r, left_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic [DIST_W-1:0]      quot_r, quot_nxt;
  logic [REM_W-1:0]       rem_r, rem_nxt;
  logic [DIST_W-1:0]      dist_r, dist_nxt;
  logic                   prev_r;

  logic [TRIG_W-1:0] trig_len_eff;
  logic [REM_W-1:0]  rem_sum;
  logic              in_window;

  // zero length trigger acts as one tick
  assign trig_len_eff = (cfg.trig_len == '0) ? TRIG_W'(1) : cfg.trig_len;
  assign rem_sum      = rem_r + DIST_NUM;
  assign in_window    = (CMP_W'(count_r) >= CMP_W'(cfg.win_min)) &&
                        (CMP_W'(count_r) <= CMP_W'(cfg.win_max));

  // next state; quotient and remainder of count*17/100 track the count
  always_comb begin
    phase_nxt = phase_r;
    left_nxt  = left_r;
    count_nxt = count_r;
    quot_nxt  = quot_r;
    rem_nxt   = rem_r;
    dist_nxt  = dist_r;
    case (phase_r)
      PH_IDLE: begin
        if (arm) begin
          left_nxt  = trig_len_eff - TRIG_W'(1);
          phase_nxt = (left_nxt == '0) ? PH_WAIT : PH_TRIG;
        end
      end
      PH_TRIG: begin
        if (left_r != '0) left_nxt = left_r - TRIG_W'(1);
        if (left_nxt == '0) phase_nxt = PH_WAIT;
      end
      PH_WAIT: begin
        if (echo && !prev_r) begin
          count_nxt = COUNT_WIDTH'(1);
          quot_nxt  = '0;
          rem_nxt   = DIST_NUM;
          phase_nxt = PH_COUNT;
        end
      end
      PH_COUNT: begin
        if (echo) begin
          if (count_r != COUNT_MAX) begin
            count_nxt = count_r + COUNT_WIDTH'(1);
            if (rem_sum >= DIST_DEN) begin
              rem_nxt = rem_sum - DIST_DEN;
              if (quot_r != DIST_MAX) quot_nxt = quot_r + DIST_W'(1);
            end else begin
              rem_nxt = rem_sum;
            end
          end
        end else begin
          dist_nxt  = quot_r;
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // per-tick status
  always_comb begin
    stat.trig = ((phase_r == PH_IDLE) && arm) || (phase_r == PH_TRIG);
    stat.done = (phase_r == PH_COUNT) && !echo;
    stat.hit  = (phase_r == PH_COUNT) && !echo && in_window;
  end

  assign range_mm = dist_nxt;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      left_r  <= '0;
      prev_r  <= 1'b0;
      dist_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      prev_r  <= echo;
      dist_r  <= dist_nxt;
    end
  end

  // echo timing datapath
  always_ff @(posedge clk) begin
    if (step) begin
      count_r <= count_nxt;
      quot_r  <= quot_nxt;
      rem_r   <= rem_nxt;
    end
  end

`ifndef SYNTHESIS
  a_fall_ends: assert property (@(posedge clk) disable iff (!rst_n)
    step && (phase_r == PH_COUNT) && !echo |=> phase_r == PH_IDLE)
    else $error("channel did not return to idle after echo fall");
  a_rise_starts: assert property (@(posedge clk) disable iff (!rst_n)
    step && (phase_r == PH_WAIT) && echo && !prev_r
      |=> (phase_r == PH_COUNT) && (count_r == COUNT_WIDTH'(1)))
    else $error("echo rise did not start the count at one");
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_COUNT |-> rem_r < DIST_DEN)
    else $error("distance remainder out of range");
`endif

endmodule

`default_nettype wire

### hdl/dur_direction.sv
// Tick timer, completion stamps and direction decision
`timescale 1ns / 1ps
`default_nettype none

module dur_direction
  import dur_pkg::*;
#(
  parameter int STAMP_WIDTH = STAMP_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic step,
  input  wire logic hit_a,
  input  wire logic hit_b,
  output logic      crossed,
  output logic      entering
);

  logic [STAMP_WIDTH-1:0] tick_r;
  logic [STAMP_WIDTH-1:0] stamp_a_r, stamp_a_nxt;
  logic [STAMP_WIDTH-1:0] stamp_b_r, stamp_b_nxt;
  logic                   seen_a_r, seen_b_r;
  logic                   pend_a, pend_b;
  logic                   dir_r, dir_nxt;

  // stamp on in-window completion, decide once both are present
  always_comb begin
    stamp_a_nxt = hit_a ? tick_r : stamp_a_r;
    stamp_b_nxt = hit_b ? tick_r : stamp_b_r;
    pend_a      = seen_a_r | hit_a;
    pend_b      = seen_b_r | hit_b;
    crossed     = pend_a & pend_b;
    dir_nxt     = crossed ? (stamp_b_nxt > stamp_a_nxt) : dir_r;
  end

  assign entering = dir_nxt;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r   <= '0;
      seen_a_r <= 1'b0;
      seen_b_r <= 1'b0;
      dir_r    <= 1'b0;
    end else if (step) begin
      tick_r   <= tick_r + STAMP_WIDTH'(1);
      seen_a_r <= pend_a & ~crossed;
      seen_b_r <= pend_b & ~crossed;
      dir_r    <= dir_nxt;
    end
  end

  // stamps are read only while their seen flag is set
  always_ff @(posedge clk) begin
    if (step) begin
      stamp_a_r <= stamp_a_nxt;
      stamp_b_r <= stamp_b_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/dual_ultrasonic_range_direction_unit.sv
// Top level: config registers, two ranging channels, direction logic, result register
// The result of a tick is registered and appears on out_* in the cycle after its input beat.
// Throughput: one tick per cycle while out_tready is high; the output register lets
//   a new beat in while the previous result is taken in the same cycle.
// Distance comes from a running quotient kept alongside the echo count, no divider.
// Reset (rst_n low, synchronous): channels idle, seen flags cleared, tick time zero,
//   registers at trigger_length 10, window 1177..5882, output empty.
`timescale 1ns / 1ps
`default_nettype none

module dual_ultrasonic_range_direction_unit
  import dur_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int STAMP_WIDTH = STAMP_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // in_tdata: arm, echo_a, echo_b, zero pad
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [7:0]            in_tdata,
  // out_tdata: trig_a, trig_b, range_a_mm[13:0], range_b_mm[13:0], range_a_new,
  //   range_b_new, crossing_done, entering, zero pad
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [39:0]                out_tdata,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t              cfg_r;
  logic              in_beat;
  logic              arm, echo_a, echo_b;
  chan_stat_t        stat_a, stat_b;
  logic [DIST_W-1:0] dist_a, dist_b;
  logic              crossed, entering;
  logic              out_valid_r;
  logic [39:0]       out_data_r, out_data_nxt;

  // input handshake
  assign in_tready = !out_valid_r || out_tready;
  assign in_beat   = in_tvalid && in_tready;
  assign arm       = in_tdata[0];
  assign echo_a    = in_tdata[1];
  assign echo_b    = in_tdata[2];

  // config registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trig_len <= TRIG_LEN_RST;
      cfg_r.win_min  <= WIN_MIN_RST;
      cfg_r.win_max  <= WIN_MAX_RST;
    end else if (cfg_valid) begin
      case (cfg_addr)
        REG_TRIG_LEN: cfg_r.trig_len <= cfg_data[TRIG_W-1:0];
        REG_WIN_MIN:  cfg_r.win_min  <= cfg_data[WIN_W-1:0];
        REG_WIN_MAX:  cfg_r.win_max  <= cfg_data[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  dur_channel #(.COUNT_WIDTH(COUNT_WIDTH)) u_chan_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (in_beat),
    .arm     (arm),
    .echo    (echo_a),
    .cfg     (cfg_r),
    .stat    (stat_a),
    .range_mm(dist_a)
  );

  dur_channel #(.COUNT_WIDTH(COUNT_WIDTH)) u_chan_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (in_beat),
    .arm     (arm),
    .echo    (echo_b),
    .cfg     (cfg_r),
    .stat    (stat_b),
    .range_mm(dist_b)
  );

  dur_direction #(.STAMP_WIDTH(STAMP_WIDTH)) u_dir (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (in_beat),
    .hit_a   (stat_a.hit),
    .hit_b   (stat_b.hit),
    .crossed (crossed),
    .entering(entering)
  );

  // result beat packing
  assign out_data_nxt = {6'd0, entering, crossed, stat_b.done, stat_a.done,
                         dist_b, dist_a, stat_b.trig, stat_a.trig};

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_beat) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled while output register empty");
  a_beat_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> out_tvalid)
    else $error("accepted beat produced no result");
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !in_beat |=> !out_tvalid)
    else $error("result repeated after it was taken");
`endif

endmodule

`default_nettype wire

### tb/tb.sv
// Testbench for the dual ultrasonic range and direction unit: stream stimulus and a scoreboard
`timescale 1ns / 1ps

module tb;
  import dur_pkg::*;

  localparam int          CYCLE_LIMIT = 1500000;
  localparam int          PHASE_TICKS = 40;
  localparam logic [CFG_ADDR_W-1:0] REG_NONE = 2'd3;

  // one result beat as it sits in out_tdata, lowest field last
  typedef struct packed {
    logic [5:0]        pad;
    logic              entering;
    logic              crossed;
    logic              new_b;
    logic              new_a;
    logic [DIST_W-1:0] range_b;
    logic [DIST_W-1:0] range_a;
    logic              trig_b;
    logic              trig_a;
  } tick_result_t;

  typedef struct packed {
    phase_t                     ph;
    logic [TRIG_W-1:0]          left;
    logic [COUNT_WIDTH_DEF-1:0] cnt;
    logic                       prev;
    logic [DIST_W-1:0]          range_mm;
    logic [STAMP_WIDTH_DEF-1:0] stamp;
    logic                       seen;
  } chan_state_t;

  // ranging predictor plus the queue of results it has worked out
  class range_scoreboard;
    logic [TRIG_W-1:0]          trig_len;
    logic [WIN_W-1:0]           win_min;
    logic [WIN_W-1:0]           win_max;
    chan_state_t                chan_a;
    chan_state_t                chan_b;
    logic [STAMP_WIDTH_DEF-1:0] tick_now;
    logic                       direction;
    tick_result_t               expected_results[$];
    int                         errors;
    int                         checked;

    function void load_reset();
      trig_len  = TRIG_LEN_RST;
      win_min   = WIN_MIN_RST;
      win_max   = WIN_MAX_RST;
      chan_a    = '0;
      chan_b    = '0;
      chan_a.ph = PH_IDLE;
      chan_b.ph = PH_IDLE;
      tick_now  = '0;
      direction = 1'b0;
      errors    = 0;
      checked   = 0;
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
      case (addr)
        REG_TRIG_LEN: trig_len = data[TRIG_W-1:0];
        REG_WIN_MIN:  win_min  = data[WIN_W-1:0];
        REG_WIN_MAX:  win_max  = data[WIN_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // one tick of one channel
    function void advance(inout chan_state_t c, input logic arm, input logic echo,
                          output logic trig, output logic done);
      logic [31:0] mm;
      trig = 1'b0;
      done = 1'b0;
      case (c.ph)
        PH_IDLE: begin
          if (arm) begin
            trig   = 1'b1;
            c.left = (trig_len == 0) ? '0 : trig_len - 1'b1;
            c.ph   = (c.left == 0) ? PH_WAIT : PH_TRIG;
          end
        end
        PH_TRIG: begin
          trig = 1'b1;
          if (c.left != 0) c.left = c.left - 1'b1;
          if (c.left == 0) c.ph = PH_WAIT;
        end
        PH_WAIT: begin
          if (echo && !c.prev) begin
            c.cnt = COUNT_WIDTH_DEF'(1);
            c.ph  = PH_COUNT;
          end
        end
        default: begin
          if (echo) begin
            if (c.cnt != '1) c.cnt = c.cnt + 1'b1;
          end else begin
            mm         = 32'(c.cnt) * 32'(DIST_NUM) / 32'(DIST_DEN);
            c.range_mm = (mm > 32'(DIST_MAX)) ? DIST_MAX : mm[DIST_W-1:0];
            done       = 1'b1;
            if (c.cnt >= win_min && c.cnt <= win_max) begin
              c.stamp = tick_now;
              c.seen  = 1'b1;
            end
            c.ph = PH_IDLE;
          end
        end
      endcase
      c.prev = echo;
    endfunction

    // predict the result of one accepted tick
    function void note_tick(logic arm, logic echo_a, logic echo_b);
      tick_result_t r;
      logic         ta, tb_trig, na, nb;
      r = '0;
      advance(chan_a, arm, echo_a, ta, na);
      advance(chan_b, arm, echo_b, tb_trig, nb);
      if (chan_a.seen && chan_b.seen) begin
        direction   = chan_b.stamp > chan_a.stamp;
        chan_a.seen = 1'b0;
        chan_b.seen = 1'b0;
        r.crossed   = 1'b1;
      end
      r.trig_a   = ta;
      r.trig_b   = tb_trig;
      r.new_a    = na;
      r.new_b    = nb;
      r.range_a  = chan_a.range_mm;
      r.range_b  = chan_b.range_mm;
      r.entering = direction;
      expected_results.push_back(r);
      tick_now = tick_now + 1'b1;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= 100)
        $display("result %0d: %s is %0h, expected %0h", checked, what, got, want);
    endtask

    task compare(string what, logic [31:0] got, logic [31:0] want);
      if (got !== want) report(what, got, want);
    endtask

    // check one accepted result beat against the oldest prediction
    task check_result(logic [39:0] word);
      tick_result_t got, want;
      got = word;
      if (expected_results.size() == 0) begin
        report("beat with nothing pending", word[31:0], 32'd0);
        return;
      end
      want = expected_results.pop_front();
      compare("trig_a", 32'(got.trig_a), 32'(want.trig_a));
      compare("trig_b", 32'(got.trig_b), 32'(want.trig_b));
      compare("range_a_mm", 32'(got.range_a), 32'(want.range_a));
      compare("range_b_mm", 32'(got.range_b), 32'(want.range_b));
      compare("range_a_new", 32'(got.new_a), 32'(want.new_a));
      compare("range_b_new", 32'(got.new_b), 32'(want.new_b));
      compare("crossing_done", 32'(got.crossed), 32'(want.crossed));
      compare("entering", 32'(got.entering), 32'(want.entering));
      compare("pad", 32'(got.pad), 32'(want.pad));
      checked++;
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // in_tdata: arm, echo_a, echo_b, zero pad
  logic [7:0]            in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // out_tdata: trig_a, trig_b, range_a_mm, range_b_mm, range_a_new, range_b_new,
  //   crossing_done, entering, zero pad
  logic [39:0]           out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  range_scoreboard sb = new();
  int              tx_gap_max = 19;
  int              rx_stall_max = 19;
  int              rx_hold_cycles = 0;
  int              tick_count = 0;

  dual_ultrasonic_range_direction_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // offer one tick beat after a random gap, wait for it to be taken
  task send_tick(logic arm, logic echo_a, logic echo_b);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, echo_b, echo_a, arm};
    do @(posedge clk); while (!in_tready);
    sb.note_tick(arm, echo_a, echo_b);
    tick_count++;
  endtask

  // register write once every pending result has drained
  task write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_reg(addr, data);
  endtask

  // arm on tick 0, then echo pulses at the given offsets from the arm tick
  task echo_burst(int lag_a, int len_a, int lag_b, int len_b, int tail,
                  bit arm_on_fall, bit stray_arms);
    int  total;
    logic arm;
    total = ((lag_a + len_a > lag_b + len_b) ? lag_a + len_a : lag_b + len_b) + tail;
    for (int t = 0; t < total; t++) begin
      arm = (t == 0) || (arm_on_fall && t == lag_a + len_a) ||
            (stray_arms && $urandom_range(0, 19) == 0);
      send_tick(arm, t >= lag_a && t < lag_a + len_a, t >= lag_b && t < lag_b + len_b);
    end
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        stall = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        stall = $urandom_range(0, rx_stall_max);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_result(out_tdata);
    end
  end

  // watchdog
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[dual_ultrasonic_range_direction_unit] ERROR");
    $finish;
  end

  // stimulus
  initial begin
    int lo, start, n, lag_a, lag_b, len_a, len_b;
    bit broken;
    sb.load_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: echo while idle, echo during trigger, arm while busy
    send_tick(1'b0, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b1, 1'b0, 1'b0);

    // zero trigger length, widest window
    write_reg(REG_TRIG_LEN, 16'd0);
    write_reg(REG_WIN_MIN, 16'd0);
    write_reg(REG_WIN_MAX, 16'hFFFF);
    // both stamps on one tick, arm on the completion tick
    echo_burst(10, 2, 10, 2, 2, 1'b1, 1'b0);
    // second channel later
    echo_burst(1, 1, 2, 2, 2, 1'b0, 1'b0);

    // masked write and a write past the register list
    write_reg(REG_TRIG_LEN, 16'hFC03);
    write_reg(REG_NONE, 16'hFFFF);
    echo_burst(4, 3, 3, 1, 2, 1'b0, 1'b0);

    // random phases of well-formed bursts mixed with noise
    for (int ph = 0; ph < 8; ph++) begin
      lo = $urandom_range(0, 25);
      write_reg(REG_TRIG_LEN, 16'($urandom_range(0, 12)));
      if (ph == 3) begin
        // window with minimum above maximum
        write_reg(REG_WIN_MIN, 16'd40);
        write_reg(REG_WIN_MAX, 16'd10);
      end else begin
        write_reg(REG_WIN_MIN, 16'(lo));
        write_reg(REG_WIN_MAX, 16'(lo + $urandom_range(0, 20)));
      end
      tx_gap_max   = (ph % 3 == 2) ? 0 : 19;
      rx_stall_max = (ph % 3 == 2) ? 0 : 19;
      if (ph == 1) rx_hold_cycles = 300;
      start = tick_count;
      while (tick_count - start < PHASE_TICKS) begin
        if ($urandom_range(0, 5) == 0) begin
          repeat ($urandom_range(8, 20))
            send_tick($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        end else begin
          n      = (sb.trig_len == 0) ? 1 : sb.trig_len;
          broken = ($urandom_range(0, 7) == 0);
          lag_a  = broken ? $urandom_range(0, n + 2) : n + $urandom_range(0, 8);
          lag_b  = broken ? $urandom_range(0, n + 2) : n + $urandom_range(0, 8);
          len_a  = $urandom_range(1, 40);
          len_b  = $urandom_range(1, 40);
          echo_burst(lag_a, len_a, lag_b, len_b, $urandom_range(1, 4),
                     $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
        end
      end
    end

    // longest trigger
    tx_gap_max   = 0;
    rx_stall_max = 0;
    write_reg(REG_TRIG_LEN, 16'd1023);
    write_reg(REG_WIN_MIN, 16'd0);
    write_reg(REG_WIN_MAX, 16'hFFFF);
    echo_burst(1023, 4, 1025, 2, 2, 1'b0, 1'b0);

    // drain
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0)
      $display("[dual_ultrasonic_range_direction_unit] OK");
    else
      $display("[dual_ultrasonic_range_direction_unit] ERROR");
    $finish;
  end

endmodule
